### hdl/rbap_pkg.sv
// Shared types and constants for the bulk array request parser.
`timescale 1ns / 1ps
package rbap_pkg;

	localparam int LEN_W = 31;
	localparam int ACC_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd536870912;
	localparam logic [LEN_W-1:0] LEN_ALL_ONES = {LEN_W{1'b1}};
	localparam logic [ACC_W-1:0] ACC_PRE_LIMIT = 32'd214748364;
	localparam logic [ACC_W-1:0] ACC_NEG_LIMIT = 32'h8000_0000;

	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		CLS_STAR   = 3'd0,
		CLS_DOLLAR = 3'd1,
		CLS_CR     = 3'd2,
		CLS_LF     = 3'd3,
		CLS_MINUS  = 3'd4,
		CLS_DIGIT  = 3'd5,
		CLS_OTHER  = 3'd6
	} cls_t;

	typedef enum logic [2:0] {
		EV_HEADER    = 3'd0,
		EV_PAYLOAD   = 3'd1,
		EV_DONE      = 3'd2,
		EV_NULL_DONE = 3'd3,
		EV_ERROR     = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_ARRAY_HDR = 3'd1,
		ERR_BULK_HDR  = 3'd2,
		ERR_NEG_LEN   = 3'd3,
		ERR_NO_CRLF   = 3'd4,
		ERR_TOO_LONG  = 3'd5
	} err_t;

	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
		logic [3:0] digit;
	} item_t;

	typedef struct packed {
		event_t           ev;
		logic [7:0]       data;
		logic [LEN_W-1:0] idx;
		logic [LEN_W-1:0] len;
		logic             done;
		err_t             code;
	} res_t;

endpackage

### hdl/resp_bulk_array_parser_core.sv
// Top level of the bulk array request parser: front, queue and back stages.
//
//   Port group   Dir   Handshake            Contents
//   request in   in    in_valid/in_ready    byte_in
//   result out   out   out_valid/out_ready  event_res .. error_code
//   config       in    cfg_we               cfg_wdata (max_item_len)
//
// One byte is taken per cycle while the result side does not stall, and
// each gives one result. A taken byte passes the front register, a queue
// entry and the result register, in that order. The back stage phase
// machine updates its accumulator and counters for one byte per cycle while
// bytes are queued and the result side does not stall. Reset clears the
// control state and sets max_item_len to 536870912. The two-entry queue lets
// the front keep taking bytes for a short while when the result side stalls.
`timescale 1ns / 1ps
module resp_bulk_array_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbap_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    byte_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    event_res,
	output logic [7:0]                    data_byte,
	output logic [rbap_pkg::LEN_W-1:0]    element_index,
	output logic [rbap_pkg::LEN_W-1:0]    element_length,
	output logic                          request_done,
	output logic [2:0]                    error_code
);

	logic            front_valid;
	logic            front_ready;
	rbap_pkg::item_t front_item;
	logic            back_valid;
	logic            back_ready;
	rbap_pkg::item_t back_item;
	rbap_pkg::res_t  res;

	rbap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_in    (byte_in),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	rbap_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	rbap_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (back_valid),
		.item_ready (back_ready),
		.item       (back_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (res)
	);

	assign event_res = res.ev;
	assign data_byte = res.data;
	assign element_index = res.idx;
	assign element_length = res.len;
	assign request_done = res.done;
	assign error_code = res.code;

endmodule

### hdl/rbap_front.sv
// Front stage: takes request bytes and classifies them into queue items.
`timescale 1ns / 1ps
module rbap_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       byte_in,
	output logic             item_valid,
	input  logic             item_ready,
	output rbap_pkg::item_t  item
);

	logic            valid_s1;
	rbap_pkg::item_t item_s1;
	rbap_pkg::item_t cls_item;

	always_comb begin
		cls_item.data = byte_in;
		cls_item.digit = 4'(byte_in - rbap_pkg::CH_ZERO);
		if (byte_in == rbap_pkg::CH_STAR) begin
			cls_item.cls = rbap_pkg::CLS_STAR;
		end else if (byte_in == rbap_pkg::CH_DOLLAR) begin
			cls_item.cls = rbap_pkg::CLS_DOLLAR;
		end else if (byte_in == rbap_pkg::CH_CR) begin
			cls_item.cls = rbap_pkg::CLS_CR;
		end else if (byte_in == rbap_pkg::CH_LF) begin
			cls_item.cls = rbap_pkg::CLS_LF;
		end else if (byte_in == rbap_pkg::CH_MINUS) begin
			cls_item.cls = rbap_pkg::CLS_MINUS;
		end else if (byte_in >= rbap_pkg::CH_ZERO && byte_in <= rbap_pkg::CH_NINE) begin
			cls_item.cls = rbap_pkg::CLS_DIGIT;
		end else begin
			cls_item.cls = rbap_pkg::CLS_OTHER;
		end
	end

	assign in_ready = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls_item;
		end
	end

endmodule

### hdl/rbap_queue.sv
// Short queue of classified bytes between the front and back stages.
`timescale 1ns / 1ps
module rbap_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  rbap_pkg::item_t  push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output rbap_pkg::item_t  pop_item
);

	rbap_pkg::item_t                 entries_q [rbap_pkg::QUEUE_DEPTH];
	logic [rbap_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [rbap_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [rbap_pkg::QUEUE_CW-1:0]   count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = count_q != rbap_pkg::QUEUE_CW'(rbap_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item = entries_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rbap_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rbap_pkg::QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + rbap_pkg::QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - rbap_pkg::QUEUE_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rbap_pkg::QUEUE_CW'(rbap_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + rbap_pkg::QUEUE_CW'(1))
		else $error("queue count missed a push");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - rbap_pkg::QUEUE_CW'(1))
		else $error("queue count missed a pop");

endmodule

### hdl/rbap_back.sv
// Back stage: request phase machine, number accumulator and result register.
`timescale 1ns / 1ps
module rbap_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbap_pkg::LEN_W-1:0]    cfg_wdata,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  rbap_pkg::item_t               item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rbap_pkg::res_t                result
);

	typedef enum logic [9:0] {
		PH_STAR     = 10'b00_0000_0001,
		PH_ARR_NUM  = 10'b00_0000_0010,
		PH_ARR_LF   = 10'b00_0000_0100,
		PH_DOLLAR   = 10'b00_0000_1000,
		PH_BULK_NUM = 10'b00_0001_0000,
		PH_BULK_LF  = 10'b00_0010_0000,
		PH_PAYLOAD  = 10'b00_0100_0000,
		PH_PAY_CR   = 10'b00_1000_0000,
		PH_PAY_LF   = 10'b01_0000_0000,
		PH_ERROR    = 10'b10_0000_0000
	} phase_t;

	phase_t                          phase_q, nx_phase;
	logic                            neg_q, nx_neg;
	logic                            digit_q, nx_digit;
	logic [rbap_pkg::ACC_W-1:0]      acc_q, nx_acc;
	logic [rbap_pkg::LEN_W-1:0]      hdr_cnt_q, nx_hdr_cnt;
	logic [rbap_pkg::LEN_W-1:0]      elem_total_q, nx_elem_total;
	logic [rbap_pkg::LEN_W-1:0]      elem_idx_q, nx_elem_idx;
	logic [rbap_pkg::LEN_W-1:0]      pay_left_q, nx_pay_left;
	logic [rbap_pkg::LEN_W-1:0]      pay_len_q, nx_pay_len;
	rbap_pkg::err_t                  held_err_q, nx_held_err;
	logic [rbap_pkg::LEN_W-1:0]      max_len_q;
	logic                            out_valid_q;
	rbap_pkg::res_t                  out_q, res;

	logic                            take;
	logic                            start;
	logic                            hdr_phase;
	logic                            neg_b;
	logic                            digit_b;
	logic [rbap_pkg::ACC_W-1:0]      acc_b;
	logic [rbap_pkg::LEN_W-1:0]      cnt_b;
	logic [rbap_pkg::LEN_W-1:0]      cnt_inc;
	logic                            in_range;
	logic [rbap_pkg::LEN_W-1:0]      num_len;
	logic [rbap_pkg::LEN_W-1:0]      fin_idx;
	logic                            fin_last;
	rbap_pkg::err_t                  err;
	rbap_pkg::err_t                  hdr_err;

	assign item_ready = !out_valid_q || out_ready;
	assign take = item_valid && item_ready;
	assign out_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		start = (phase_q == PH_STAR) || (phase_q == PH_DOLLAR);
		hdr_phase = (phase_q == PH_STAR) || (phase_q == PH_ARR_NUM) ||
			(phase_q == PH_ARR_LF) || (phase_q == PH_DOLLAR) ||
			(phase_q == PH_BULK_NUM) || (phase_q == PH_BULK_LF);
		neg_b = start ? 1'b0 : neg_q;
		digit_b = start ? 1'b0 : digit_q;
		acc_b = start ? '0 : acc_q;
		cnt_b = start ? '0 : hdr_cnt_q;
		cnt_inc = (cnt_b == rbap_pkg::LEN_ALL_ONES) ? cnt_b : cnt_b + 31'd1;
		in_range = !acc_q[rbap_pkg::ACC_W-1] ||
			(neg_q && acc_q == rbap_pkg::ACC_NEG_LIMIT);
		num_len = neg_q ? '0 : acc_q[rbap_pkg::LEN_W-1:0];
		fin_idx = elem_idx_q + 31'd1;
		fin_last = fin_idx >= elem_total_q;
		hdr_err = (phase_q == PH_ARR_NUM) ? rbap_pkg::ERR_ARRAY_HDR : rbap_pkg::ERR_BULK_HDR;

		nx_phase = phase_q;
		nx_neg = neg_b;
		nx_digit = digit_b;
		nx_acc = acc_b;
		nx_hdr_cnt = cnt_b;
		nx_elem_total = elem_total_q;
		nx_elem_idx = elem_idx_q;
		nx_pay_left = pay_left_q;
		nx_pay_len = pay_len_q;
		nx_held_err = held_err_q;
		err = rbap_pkg::ERR_NONE;

		res.ev = rbap_pkg::EV_HEADER;
		res.data = item.data;
		res.idx = elem_idx_q;
		res.len = '0;
		res.done = 1'b0;
		res.code = rbap_pkg::ERR_NONE;

		// The header length check wins over any format check on the same byte.
		if (hdr_phase) begin
			nx_hdr_cnt = cnt_inc;
			if (cnt_inc > max_len_q) begin
				err = rbap_pkg::ERR_TOO_LONG;
			end
		end

		if (err == rbap_pkg::ERR_NONE) begin
			case (phase_q)
				PH_STAR: begin
					if (item.cls == rbap_pkg::CLS_STAR) begin
						nx_phase = PH_ARR_NUM;
					end else begin
						err = rbap_pkg::ERR_ARRAY_HDR;
					end
				end
				PH_DOLLAR: begin
					if (item.cls == rbap_pkg::CLS_DOLLAR) begin
						nx_phase = PH_BULK_NUM;
					end else begin
						err = rbap_pkg::ERR_BULK_HDR;
					end
				end
				PH_ARR_NUM, PH_BULK_NUM: begin
					if (item.cls == rbap_pkg::CLS_CR) begin
						if (digit_b) begin
							nx_phase = (phase_q == PH_ARR_NUM) ? PH_ARR_LF : PH_BULK_LF;
						end else begin
							err = hdr_err;
						end
					end else if (item.cls == rbap_pkg::CLS_MINUS && !neg_b && !digit_b) begin
						nx_neg = 1'b1;
					end else if (item.cls == rbap_pkg::CLS_DIGIT) begin
						if (acc_b > rbap_pkg::ACC_PRE_LIMIT) begin
							err = hdr_err;
						end else begin
							nx_acc = {acc_b[28:0], 3'b000} + {acc_b[30:0], 1'b0} +
								{28'd0, item.digit};
							nx_digit = 1'b1;
						end
					end else begin
						err = hdr_err;
					end
				end
				PH_ARR_LF: begin
					if (item.cls != rbap_pkg::CLS_LF || !in_range ||
						(neg_q && acc_q != '0)) begin
						err = rbap_pkg::ERR_ARRAY_HDR;
					end else begin
						nx_elem_total = num_len;
						nx_elem_idx = '0;
						res.idx = '0;
						if (num_len == '0) begin
							res.done = 1'b1;
							nx_phase = PH_STAR;
						end else begin
							nx_phase = PH_DOLLAR;
						end
					end
				end
				PH_BULK_LF: begin
					if (item.cls != rbap_pkg::CLS_LF || !in_range) begin
						err = rbap_pkg::ERR_BULK_HDR;
					end else if (neg_q && acc_q == 32'd1) begin
						// A length of minus one is a null element.
						res.ev = rbap_pkg::EV_NULL_DONE;
						res.done = fin_last;
						nx_elem_idx = fin_last ? '0 : fin_idx;
						nx_elem_total = fin_last ? '0 : elem_total_q;
						nx_phase = fin_last ? PH_STAR : PH_DOLLAR;
					end else if (neg_q && acc_q > 32'd1) begin
						err = rbap_pkg::ERR_NEG_LEN;
					end else begin
						nx_pay_len = num_len;
						if (num_len > max_len_q) begin
							err = rbap_pkg::ERR_TOO_LONG;
						end else begin
							nx_pay_left = num_len;
							nx_phase = (num_len == '0) ? PH_PAY_CR : PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					res.ev = rbap_pkg::EV_PAYLOAD;
					res.len = pay_len_q;
					nx_pay_left = pay_left_q - 31'd1;
					if (pay_left_q == 31'd1) begin
						nx_phase = PH_PAY_CR;
					end
				end
				PH_PAY_CR: begin
					if (item.cls == rbap_pkg::CLS_CR) begin
						nx_phase = PH_PAY_LF;
					end else begin
						err = rbap_pkg::ERR_NO_CRLF;
					end
				end
				PH_PAY_LF: begin
					if (item.cls == rbap_pkg::CLS_LF) begin
						res.ev = rbap_pkg::EV_DONE;
						res.len = pay_len_q;
						res.done = fin_last;
						nx_elem_idx = fin_last ? '0 : fin_idx;
						nx_elem_total = fin_last ? '0 : elem_total_q;
						nx_phase = fin_last ? PH_STAR : PH_DOLLAR;
					end else begin
						err = rbap_pkg::ERR_NO_CRLF;
					end
				end
				default: begin
					err = held_err_q;
				end
			endcase
		end

		// Errors are sticky: every later byte reports the first code.
		if (err != rbap_pkg::ERR_NONE || phase_q == PH_ERROR) begin
			nx_held_err = (phase_q == PH_ERROR) ? held_err_q : err;
			nx_phase = PH_ERROR;
			res.ev = rbap_pkg::EV_ERROR;
			res.idx = '0;
			res.len = '0;
			res.done = 1'b0;
			res.code = nx_held_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAR;
			neg_q <= 1'b0;
			digit_q <= 1'b0;
			acc_q <= '0;
			hdr_cnt_q <= '0;
			elem_total_q <= '0;
			elem_idx_q <= '0;
			pay_left_q <= '0;
			pay_len_q <= '0;
			held_err_q <= rbap_pkg::ERR_NONE;
			max_len_q <= rbap_pkg::MAX_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (take) begin
				phase_q <= nx_phase;
				neg_q <= nx_neg;
				digit_q <= nx_digit;
				acc_q <= nx_acc;
				hdr_cnt_q <= nx_hdr_cnt;
				elem_total_q <= nx_elem_total;
				elem_idx_q <= nx_elem_idx;
				pay_left_q <= nx_pay_left;
				pay_len_q <= nx_pay_len;
				held_err_q <= nx_held_err;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("left the error phase without reset");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ev == rbap_pkg::EV_ERROR) |-> out_q.code != rbap_pkg::ERR_NONE)
		else $error("error result without a code");

	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ev != rbap_pkg::EV_ERROR) |->
		(out_q.code == rbap_pkg::ERR_NONE && phase_q != PH_ERROR))
		else $error("error code on a normal result");

	a_held_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ev == rbap_pkg::EV_ERROR) |-> out_q.code == held_err_q)
		else $error("error result disagrees with the held code");

endmodule

### tb/resp_parse_checker.sv
// Scoreboard for the bulk array request parser: predicts every result and compares it.
`timescale 1ns / 1ps
module resp_parse_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rbap_pkg::LEN_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [7:0]                 byte_in,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [2:0]                 event_res,
	input  logic [7:0]                 data_byte,
	input  logic [rbap_pkg::LEN_W-1:0] element_index,
	input  logic [rbap_pkg::LEN_W-1:0] element_length,
	input  logic                       request_done,
	input  logic [2:0]                 error_code,
	output int                         fail_count,
	output int                         pending
);
	import rbap_pkg::*;

	typedef enum logic [3:0] {
		ST_ARRAY_MARK,
		ST_ARRAY_NUM,
		ST_ARRAY_LF,
		ST_BULK_MARK,
		ST_BULK_NUM,
		ST_BULK_LF,
		ST_PAYLOAD,
		ST_TRAIL_CR,
		ST_TRAIL_LF,
		ST_FAILED
	} parse_phase_t;

	parse_phase_t phase;
	bit neg;
	bit dig;
	logic [ACC_W-1:0] num_val;
	logic [LEN_W-1:0] hdr_bytes;
	logic [LEN_W-1:0] elem_total;
	logic [LEN_W-1:0] elem_idx;
	logic [LEN_W-1:0] pay_left;
	logic [LEN_W-1:0] pay_len;
	logic [LEN_W-1:0] max_len;
	err_t held;

	res_t expected_events[$];
	res_t want;
	int fails;

	function automatic bit take_num_char(input logic [7:0] b);
		if (b == CH_MINUS && !neg && !dig) begin
			neg = 1'b1;
			return 1'b1;
		end
		if (b >= CH_ZERO && b <= CH_NINE) begin
			if (num_val > ACC_PRE_LIMIT)
				return 1'b0;
			num_val = num_val * 32'd10 + {24'd0, b - CH_ZERO};
			dig = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit num_fits();
		return num_val <= (neg ? ACC_NEG_LIMIT : {1'b0, LEN_ALL_ONES});
	endfunction

	// Returns 1 when the element just closed was the last of the request.
	function automatic bit close_element();
		elem_idx = elem_idx + 1'b1;
		if (elem_idx >= elem_total) begin
			elem_idx = '0;
			elem_total = '0;
			phase = ST_ARRAY_MARK;
			return 1'b1;
		end
		phase = ST_BULK_MARK;
		return 1'b0;
	endfunction

	function automatic res_t parse_byte(input logic [7:0] b);
		res_t r;
		err_t e;
		err_t hdr_e;
		r.ev = EV_HEADER;
		r.data = b;
		r.idx = elem_idx;
		r.len = '0;
		r.done = 1'b0;
		r.code = ERR_NONE;
		e = ERR_NONE;
		hdr_e = (phase <= ST_ARRAY_LF) ? ERR_ARRAY_HDR : ERR_BULK_HDR;
		if (phase == ST_ARRAY_MARK || phase == ST_BULK_MARK) begin
			neg = 1'b0;
			dig = 1'b0;
			num_val = '0;
			hdr_bytes = '0;
		end
		// The length limit is checked ahead of the format of the same byte.
		if (phase <= ST_BULK_LF) begin
			if (hdr_bytes != LEN_ALL_ONES)
				hdr_bytes = hdr_bytes + 1'b1;
			if (hdr_bytes > max_len)
				e = ERR_TOO_LONG;
		end
		if (e == ERR_NONE) begin
			case (phase)
				ST_ARRAY_MARK: begin
					if (b == CH_STAR) phase = ST_ARRAY_NUM;
					else e = ERR_ARRAY_HDR;
				end
				ST_BULK_MARK: begin
					if (b == CH_DOLLAR) phase = ST_BULK_NUM;
					else e = ERR_BULK_HDR;
				end
				ST_ARRAY_NUM, ST_BULK_NUM: begin
					if (b == CH_CR) begin
						if (!dig) e = hdr_e;
						else if (phase == ST_ARRAY_NUM) phase = ST_ARRAY_LF;
						else phase = ST_BULK_LF;
					end else if (!take_num_char(b)) begin
						e = hdr_e;
					end
				end
				ST_ARRAY_LF: begin
					if (b != CH_LF || !num_fits() || (neg && num_val != 0)) begin
						e = ERR_ARRAY_HDR;
					end else begin
						elem_total = neg ? '0 : num_val[LEN_W-1:0];
						elem_idx = '0;
						r.idx = '0;
						if (elem_total == 0) begin
							r.done = 1'b1;
							phase = ST_ARRAY_MARK;
						end else begin
							phase = ST_BULK_MARK;
						end
					end
				end
				ST_BULK_LF: begin
					if (b != CH_LF || !num_fits()) begin
						e = ERR_BULK_HDR;
					end else if (neg && num_val == 1) begin
						r.ev = EV_NULL_DONE;
						r.done = close_element();
					end else if (neg && num_val > 1) begin
						e = ERR_NEG_LEN;
					end else begin
						pay_len = neg ? '0 : num_val[LEN_W-1:0];
						if (pay_len > max_len) begin
							e = ERR_TOO_LONG;
						end else begin
							pay_left = pay_len;
							phase = (pay_len == 0) ? ST_TRAIL_CR : ST_PAYLOAD;
						end
					end
				end
				ST_PAYLOAD: begin
					r.ev = EV_PAYLOAD;
					r.len = pay_len;
					pay_left = pay_left - 1'b1;
					if (pay_left == 0)
						phase = ST_TRAIL_CR;
				end
				ST_TRAIL_CR: begin
					if (b == CH_CR) phase = ST_TRAIL_LF;
					else e = ERR_NO_CRLF;
				end
				ST_TRAIL_LF: begin
					if (b == CH_LF) begin
						r.ev = EV_DONE;
						r.len = pay_len;
						r.done = close_element();
					end else begin
						e = ERR_NO_CRLF;
					end
				end
				default: e = held;
			endcase
		end
		// The first error sticks until reset.
		if (e != ERR_NONE || phase == ST_FAILED) begin
			if (e == ERR_NONE)
				e = held;
			held = e;
			phase = ST_FAILED;
			r.ev = EV_ERROR;
			r.idx = '0;
			r.len = '0;
			r.done = 1'b0;
			r.code = e;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = ST_ARRAY_MARK;
			neg = 1'b0;
			dig = 1'b0;
			num_val = '0;
			hdr_bytes = '0;
			elem_total = '0;
			elem_idx = '0;
			pay_left = '0;
			pay_len = '0;
			max_len = MAX_LEN_RESET;
			held = ERR_NONE;
			expected_events.delete();
			fails = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: ev=%0d data=%02h idx=%0d len=%0d done=%0b err=%0d",
							event_res, data_byte, element_index, element_length,
							request_done, error_code);
				end else begin
					want = expected_events.pop_front();
					if (event_res !== want.ev || data_byte !== want.data ||
					    element_index !== want.idx || element_length !== want.len ||
					    request_done !== want.done || error_code !== want.code) begin
						fails++;
						if (fails <= 10)
							$display("result mismatch: expected ev=%0d data=%02h idx=%0d len=%0d done=%0b err=%0d, got ev=%0d data=%02h idx=%0d len=%0d done=%0b err=%0d",
								want.ev, want.data, want.idx, want.len, want.done, want.code,
								event_res, data_byte, element_index, element_length,
								request_done, error_code);
					end
				end
			end
			if (cfg_we)
				max_len = cfg_wdata;
			if (in_valid && in_ready)
				expected_events.push_back(parse_byte(byte_in));
			pending <= expected_events.size();
			fail_count <= fails;
		end
	end

endmodule

### tb/tb_resp_bulk_array_parser_core.sv
// Top of the parser testbench: clock, reset, request stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_resp_bulk_array_parser_core;
	import rbap_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_CHOKED
	} rx_mode_t;

	typedef enum int {
		FLT_ARRAY_MARKER,
		FLT_ARRAY_NUMBER,
		FLT_NEG_COUNT,
		FLT_ARRAY_RANGE,
		FLT_BULK_MARKER,
		FLT_BULK_NUMBER,
		FLT_LEN_BELOW,
		FLT_NO_CRLF,
		FLT_HDR_TOO_LONG,
		FLT_BULK_TOO_LONG
	} fault_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [7:0] byte_in;
	logic out_valid;
	logic out_ready;
	logic [2:0] event_res;
	logic [7:0] data_byte;
	logic [LEN_W-1:0] element_index;
	logic [LEN_W-1:0] element_length;
	logic request_done;
	logic [2:0] error_code;

	int fail_count;
	int pending;
	int cycles;
	int burst_left;
	int sent;
	logic [LEN_W-1:0] cur_max;
	logic [7:0] stream_q[$];
	rx_mode_t rx_mode;
	int rx_left;
	int rx_tick;

	resp_bulk_array_parser_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte_in        (byte_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_res      (event_res),
		.data_byte      (data_byte),
		.element_index  (element_index),
		.element_length (element_length),
		.request_done   (request_done),
		.error_code     (error_code)
	);

	resp_parse_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte_in        (byte_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_res      (event_res),
		.data_byte      (data_byte),
		.element_index  (element_index),
		.element_length (element_length),
		.request_done   (request_done),
		.error_code     (error_code),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// The result side switches between open, coin-flip, periodic and choked stretches.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_left <= 0;
			rx_tick <= 0;
			rx_mode <= RX_OPEN;
		end else begin
			rx_tick <= rx_tick + 1;
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(RX_OPEN, RX_CHOKED));
				rx_left <= $urandom_range(20, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:     out_ready <= 1'b1;
				RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
				RX_PERIODIC: out_ready <= (rx_tick % 5 != 0);
				default:     out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		burst_left--;
		sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_stream();
		while (stream_q.size() != 0)
			send_byte(stream_q.pop_front());
	endtask

	// Holds off new requests until every expected result has been seen.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [LEN_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		cur_max = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stream_q.push_back(s[i]);
	endtask

	task automatic push_crlf();
		stream_q.push_back(CH_CR);
		stream_q.push_back(CH_LF);
	endtask

	// Leading zeros are trimmed so that they alone never push the header over the length limit.
	task automatic push_header(input logic [7:0] pfx, input int unsigned mag, input bit neg,
			input int zeros);
		string digits;
		digits = $sformatf("%0d", mag);
		while (zeros > 0 && 3 + neg + zeros + digits.len() > cur_max)
			zeros--;
		stream_q.push_back(pfx);
		if (neg)
			stream_q.push_back(CH_MINUS);
		repeat (zeros) stream_q.push_back(CH_ZERO);
		push_text(digits);
		push_crlf();
	endtask

	function automatic int pick_zeros();
		return ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 2);
	endfunction

	task automatic queue_request();
		int n;
		int kind;
		int len;
		int cap;
		if ($urandom_range(0, 9) == 0) begin
			push_header(CH_STAR, 0, 1'($urandom_range(0, 1)), pick_zeros());
			return;
		end
		n = $urandom_range(1, 4);
		push_header(CH_STAR, n, 1'b0, pick_zeros());
		for (int e = 0; e < n; e++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				push_header(CH_DOLLAR, 1, 1'b1, pick_zeros());
			end else if (kind == 1) begin
				push_header(CH_DOLLAR, 0, 1'($urandom_range(0, 1)), pick_zeros());
				push_crlf();
			end else begin
				cap = (cur_max < 12) ? int'(cur_max) : 12;
				if (cur_max >= 40 && $urandom_range(0, 9) == 0)
					cap = 40;
				len = $urandom_range(1, cap);
				push_header(CH_DOLLAR, len, 1'b0, pick_zeros());
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 5) == 0) begin
						case ($urandom_range(0, 3))
							0:       stream_q.push_back(CH_CR);
							1:       stream_q.push_back(CH_LF);
							2:       stream_q.push_back(CH_STAR);
							default: stream_q.push_back(CH_DOLLAR);
						endcase
					end else begin
						stream_q.push_back(8'($urandom_range(0, 255)));
					end
				end
				push_crlf();
			end
		end
	endtask

	initial begin
		int goal;
		int variant;
		logic [LEN_W-1:0] v;
		logic [7:0] pick;
		fault_t fault;
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycles = 0;
		burst_left = 0;
		sent = 0;
		cur_max = MAX_LEN_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty request written as minus zero, then a null element and a
		// zero-padded length carrying the extreme payload values.
		push_text("*-0");
		push_crlf();
		push_header(CH_STAR, 2, 1'b0, 0);
		push_header(CH_DOLLAR, 1, 1'b1, 0);
		push_header(CH_DOLLAR, 2, 1'b0, 1);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		push_crlf();
		send_stream();

		for (int k = 0; k < 5; k++) begin
			case (k)
				0:       v = LEN_ALL_ONES;
				1:       v = 31'd8;
				2:       v = 31'd64;
				3:       v = LEN_W'($urandom_range(8, 40));
				default: v = LEN_W'($urandom_range(41, 1000000));
			endcase
			write_max_len(v);
			goal = sent + 140;
			while (sent < goal) begin
				queue_request();
				send_stream();
			end
			if (k == 1) begin
				// A limit of one still lets the trailing CRLF of a payload through.
				push_header(CH_STAR, 1, 1'b0, 0);
				push_header(CH_DOLLAR, 1, 1'b0, 0);
				stream_q.push_back(8'($urandom_range(0, 255)));
				send_stream();
				write_max_len(31'd1);
				push_crlf();
				send_stream();
			end
		end

		// One error per run, since only reset clears it; the kind is drawn at random.
		fault = fault_t'($urandom_range(FLT_ARRAY_MARKER, FLT_BULK_TOO_LONG));
		variant = $urandom_range(0, 3);
		case (fault)
			FLT_ARRAY_MARKER: begin
				do pick = 8'($urandom_range(0, 255)); while (pick == CH_STAR);
				stream_q.push_back(pick);
			end
			FLT_ARRAY_NUMBER: begin
				push_text("*");
				case (variant)
					0: push_text("1a");
					1: stream_q.push_back(CH_CR);
					2: begin
						push_text("12");
						stream_q.push_back(CH_CR);
						push_text("x");
					end
					default: push_text("1-");
				endcase
			end
			FLT_NEG_COUNT: begin
				push_text("*-");
				stream_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
				push_crlf();
			end
			FLT_ARRAY_RANGE: begin
				if (variant < 2) push_text("*2147483648");
				else push_text("*21474836470");
				push_crlf();
			end
			FLT_BULK_MARKER: begin
				push_header(CH_STAR, 1, 1'b0, 0);
				do pick = 8'($urandom_range(0, 255)); while (pick == CH_DOLLAR);
				stream_q.push_back(pick);
			end
			FLT_BULK_NUMBER: begin
				push_header(CH_STAR, 1, 1'b0, 0);
				push_text("$");
				case (variant)
					0: stream_q.push_back(CH_CR);
					1: push_text("1x");
					2: begin
						push_text("2147483648");
						push_crlf();
					end
					default: begin
						push_text("12");
						stream_q.push_back(CH_CR);
						push_text("x");
					end
				endcase
			end
			FLT_LEN_BELOW: begin
				push_header(CH_STAR, 2, 1'b0, 0);
				if (variant < 2) push_text("$-2");
				else push_text("$-2147483648");
				push_crlf();
			end
			FLT_NO_CRLF: begin
				push_header(CH_STAR, 1, 1'b0, 0);
				push_header(CH_DOLLAR, 1, 1'b0, 0);
				stream_q.push_back(8'($urandom_range(0, 255)));
				if (variant < 2) begin
					do pick = 8'($urandom_range(0, 255)); while (pick == CH_CR);
				end else begin
					stream_q.push_back(CH_CR);
					do pick = 8'($urandom_range(0, 255)); while (pick == CH_LF);
				end
				stream_q.push_back(pick);
			end
			FLT_HDR_TOO_LONG: begin
				write_max_len(LEN_W'($urandom_range(1, 3)));
				push_header(CH_STAR, 1, 1'b0, 0);
			end
			default: begin
				write_max_len(31'd8);
				push_header(CH_STAR, 1, 1'b0, 0);
				push_header(CH_DOLLAR, 9, 1'b0, 0);
			end
		endcase
		// Well-formed and random bytes after the error must all report it.
		push_header(CH_STAR, 1, 1'b0, 0);
		repeat (24) stream_q.push_back(8'($urandom_range(0, 255)));
		send_stream();

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
